/* design/dtls_ack_record_parser_core_assert.svh */
// Assertion macros shared by the parser modules. Each expands in a module that
// has clk_i and rst_ni in scope.
`ifndef DTLS_ACK_RECORD_PARSER_CORE_ASSERT_SVH
`define DTLS_ACK_RECORD_PARSER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define DAP_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger at one edge implies a consequence at the next edge.
`define DAP_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* design/dap_pkg.sv */
`default_nettype none

package dap_pkg;

  localparam int unsigned LengthFieldBytes  = 2;
  localparam int unsigned RecordNumberBytes = 16;
  localparam int unsigned HalfRecordBytes   = RecordNumberBytes / 2;
  localparam int unsigned PayloadSat        = 65536;

  localparam int unsigned HdrCntW  = 2;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PayCntW  = 17;
  localparam int unsigned PosW     = 4;
  localparam int unsigned WordW    = 64;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [StatusW-1:0] {
    StOk          = 2'd0,
    StTooShort    = 2'd1,
    StLenMismatch = 2'd2,
    StNotMultiple = 2'd3
  } dap_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dap_item_t;

  typedef struct packed {
    logic             vld;
    dap_item_t        item;
  } dap_stage_t;

  typedef struct packed {
    logic             record_valid;
    logic [WordW-1:0] epoch;
    logic [WordW-1:0] sequence_res;
    logic             finished;
    dap_status_e      status;
  } dap_result_t;

endpackage

`default_nettype wire

/* design/dap_in_if.sv */
`default_nettype none

interface dap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* design/dap_out_if.sv */
`default_nettype none

interface dap_out_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [63:0] epoch;
  logic [63:0] sequence_res;
  logic        finished;
  logic [1:0]  status;

  modport source (
    output valid, output record_valid, output epoch, output sequence_res,
    output finished, output status, input ready
  );
  modport sink (
    input valid, input record_valid, input epoch, input sequence_res,
    input finished, input status, output ready
  );
endinterface

`default_nettype wire

/* design/dtls_ack_record_parser_core.sv */
`default_nettype none

// DTLS 1.3 ACK record parser. Feed the record one byte per transaction on rx_i,
// in wire order, with last_byte set on its final byte. The first two bytes are the
// big-endian payload length; each following group of 16 bytes is decoded into a
// 64-bit epoch and a 64-bit sequence number, and a result goes out on tx_o with
// record_valid set as soon as the group completes. The closing byte always yields
// a result with finished set and status (ok, too short, length mismatch, not a
// multiple of 16); a record number completed by that byte rides on the same
// result. Record numbers leave before the record is checked, so discard them when
// the closing status is not ok. The block takes one byte per cycle while the output
// buffer has room; each byte passes through an input register, the byte counters and
// assembly shift registers, and a two-entry output buffer that lets rx_i keep
// moving while a result waits.

module dtls_ack_record_parser_core
  import dap_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dap_in_if.sink      rx_i,
  dap_out_if.source   tx_o
);

  dap_item_t   rx_item;
  dap_stage_t  stage;
  dap_result_t result;
  dap_result_t head;
  logic        buf_ready;
  logic        advance;
  logic        push;

  assign rx_item = '{data_byte: rx_i.data_byte, last_byte: rx_i.last_byte};

  // Move the held byte into the parser whenever the output buffer has room.
  assign advance = stage.vld && buf_ready;

  dap_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .item_i    (rx_item),
    .ready_o   (rx_i.ready),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // Parse one byte per advance; push a result only for a completed record
  // number or a closing byte.
  dap_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .fire_i   (advance),
    .push_o   (push),
    .result_o (result)
  );

  dap_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (buf_ready),
    .valid_o (tx_o.valid),
    .pop_i   (tx_o.ready),
    .data_o  (head)
  );

  assign tx_o.record_valid = head.record_valid;
  assign tx_o.epoch        = head.epoch;
  assign tx_o.sequence_res = head.sequence_res;
  assign tx_o.finished     = head.finished;
  assign tx_o.status       = head.status;

endmodule

`default_nettype wire

/* design/dap_in_stage.sv */
`default_nettype none

module dap_in_stage
  import dap_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire dap_item_t  item_i,
  output logic            ready_o,
  input  wire logic       advance_i,
  output dap_stage_t      stage_o
);

  logic      vld_q, vld_d;
  dap_item_t item_q;

  // Take a new byte when empty or when the held one moves on this cycle.
  assign ready_o = !vld_q || advance_i;

  always_comb begin
    vld_d = vld_q;
    if (valid_i && ready_o) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign stage_o = '{vld: vld_q, item: item_q};

endmodule

`default_nettype wire

/* design/dap_engine.sv */
`default_nettype none

`include "dtls_ack_record_parser_core_assert.svh"

module dap_engine
  import dap_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dap_stage_t stage_i,
  input  wire logic       fire_i,
  output logic            push_o,
  output dap_result_t     result_o
);

  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]    decl_len_q, decl_len_d;
  logic [PayCntW-1:0] pay_cnt_q, pay_cnt_d;
  logic [WordW-1:0]   shift_ep_q, shift_ep_d;
  logic [WordW-1:0]   shift_sq_q, shift_sq_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               rec_done;
  logic [7:0]         b;
  logic               last;
  dap_status_e        st;

  localparam logic [HdrCntW-1:0] HdrFull   = HdrCntW'(LengthFieldBytes);
  localparam logic [PosW-1:0]    PosLast   = PosW'(RecordNumberBytes - 1);
  localparam logic [PosW-1:0]    PosHalf   = PosW'(HalfRecordBytes);
  localparam logic [PayCntW-1:0] PaySatVal = PayCntW'(PayloadSat);

  assign b    = stage_i.item.data_byte;
  assign last = stage_i.item.last_byte;

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    decl_len_d = decl_len_q;
    pay_cnt_d  = pay_cnt_q;
    shift_ep_d = shift_ep_q;
    shift_sq_d = shift_sq_q;
    pos_d      = pos_q;
    rec_done   = 1'b0;

    if (hdr_cnt_q != HdrFull) begin
      // Shift in the big-endian length field.
      decl_len_d = {decl_len_q[LenW-9:0], b};
      hdr_cnt_d  = hdr_cnt_q + HdrCntW'(1);
    end else begin
      if (pay_cnt_q != PaySatVal) begin
        pay_cnt_d = pay_cnt_q + PayCntW'(1);
      end
      if (pos_q < PosHalf) begin
        shift_ep_d = {shift_ep_q[WordW-9:0], b};
      end else begin
        shift_sq_d = {shift_sq_q[WordW-9:0], b};
      end
      rec_done = (pos_q == PosLast);
      pos_d    = pos_q + PosW'(1);
    end

    if (hdr_cnt_d != HdrFull) begin
      st = StTooShort;
    end else if (pay_cnt_d != {1'b0, decl_len_d}) begin
      st = StLenMismatch;
    end else if (pay_cnt_d[PosW-1:0] != '0) begin
      st = StNotMultiple;
    end else begin
      st = StOk;
    end

    result_o.record_valid = rec_done;
    result_o.epoch        = rec_done ? shift_ep_d : '0;
    result_o.sequence_res = rec_done ? shift_sq_d : '0;
    result_o.finished     = last;
    result_o.status       = last ? st : StOk;

    // Drop back to the start state once the record is closed.
    if (last) begin
      hdr_cnt_d  = '0;
      decl_len_d = '0;
      pay_cnt_d  = '0;
      pos_d      = '0;
    end
  end

  assign push_o = fire_i && (rec_done || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= '0;
      decl_len_q <= '0;
      pay_cnt_q  <= '0;
      shift_ep_q <= '0;
      shift_sq_q <= '0;
      pos_q      <= '0;
    end else if (fire_i) begin
      hdr_cnt_q  <= hdr_cnt_d;
      decl_len_q <= decl_len_d;
      pay_cnt_q  <= pay_cnt_d;
      shift_ep_q <= shift_ep_d;
      shift_sq_q <= shift_sq_d;
      pos_q      <= pos_d;
    end
  end

  `DAP_ASSERT_NOW(a_hdr_cnt_range, hdr_cnt_q <= HdrFull, "header count out of range")
  `DAP_ASSERT_NOW(a_pos_idle_in_hdr, (hdr_cnt_q == HdrFull) || (pos_q == '0 && pay_cnt_q == '0), "payload state moved during length field")
  `DAP_ASSERT_NEXT(a_reset_after_last, fire_i && last, hdr_cnt_q == '0 && pos_q == '0 && pay_cnt_q == '0, "state not cleared after closing byte")

endmodule

`default_nettype wire

/* design/dap_out_buf.sv */
`default_nettype none

`include "dtls_ack_record_parser_core_assert.svh"

module dap_out_buf
  import dap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire dap_result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  wire logic        pop_i,
  output dap_result_t      data_o
);

  dap_result_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `DAP_ASSERT_NOW(a_no_push_full, !(push_i && count_q == 2'd2), "push into full buffer")
  `DAP_ASSERT_NEXT(a_head_holds, count_q != 2'd0 && !do_pop, $stable(data_o), "head changed without pop")
  `DAP_ASSERT_NEXT(a_count_up, push_i && !do_pop, count_q == $past(count_q) + 2'd1, "count did not advance on push")

endmodule

`default_nettype wire
